// ===== rtl/status_text_chunk_packer_assert.svh =====
// Assertion macros for the status text chunk packer.
// Needs a clock named clk and a synchronous active-high reset named rst in scope.
`ifndef STATUS_TEXT_CHUNK_PACKER_ASSERT_SVH
`define STATUS_TEXT_CHUNK_PACKER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define STCP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("stcp assertion failed");

// Next-cycle implication, disabled during reset.
`define STCP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("stcp assertion failed");

`endif

// ===== rtl/stcp_pkg.sv =====
// Shared types and constants for the status text chunk packer.
// No dependencies.
package stcp_pkg;

  localparam int unsigned CharW  = 8;
  localparam int unsigned SevW   = 3;
  localparam int unsigned RateW  = 8;
  localparam int unsigned WordW  = 32;
  localparam int unsigned CopyW  = 2;
  localparam int unsigned CfgIdxW = 1;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_LOW_RATE = 1'd0;
  localparam logic [CfgIdxW-1:0] REG_MID_RATE = 1'd1;

  localparam logic [RateW-1:0] LOW_RATE_RESET = 8'd20;
  localparam logic [RateW-1:0] MID_RATE_RESET = 8'd30;

  localparam logic [CopyW-1:0] COPIES_ONE   = 2'd1;
  localparam logic [CopyW-1:0] COPIES_TWO   = 2'd2;
  localparam logic [CopyW-1:0] COPIES_THREE = 2'd3;

  // Outcome of packing one character
  typedef struct packed {
    logic [WordW-1:0] word;
    logic             done;
    logic             msg_end;
  } pack_result_t;

endpackage

// ===== rtl/stcp_pack.sv =====
// Character accumulator: folds characters into a 32-bit word and flags completion.
// Depends on stcp_pkg.
module stcp_pack #(
  parameter int unsigned TEXT_LEN = 50
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        commit,
  input  logic [stcp_pkg::CharW-1:0]  character,
  input  logic [stcp_pkg::SevW-1:0]   severity,
  output stcp_pkg::pack_result_t      result
);
  import stcp_pkg::*;

  localparam int unsigned PosW = $clog2(TEXT_LEN + 1);

  logic [WordW-1:0] acc, acc_next, acc_or;
  logic [1:0]       slot, slot_next;
  logic [PosW-1:0]  pos, pos_next, pos_inc;
  logic [WordW-1:0] sev_bits;
  logic             done, msg_end;

  always_comb begin
    case (slot)
      2'd0:    acc_or = acc | {character, 24'd0};
      2'd1:    acc_or = acc | {8'd0, character, 16'd0};
      2'd2:    acc_or = acc | {16'd0, character, 8'd0};
      default: acc_or = acc | {24'd0, character};
    endcase
    pos_inc  = pos + 1'b1;
    sev_bits = {8'd0, severity[2], 7'd0, severity[1], 7'd0, severity[0], 7'd0};

    // NUL closes the message and adds no byte
    if (character == '0) begin
      done    = 1'b1;
      msg_end = 1'b1;
    end else begin
      msg_end = (pos_inc == PosW'(TEXT_LEN));
      done    = (slot == 2'd3) || msg_end;
    end

    result.done    = done;
    result.msg_end = msg_end;
    if (character == '0) begin
      result.word = acc | sev_bits;
    end else if (msg_end) begin
      result.word = acc_or | sev_bits;
    end else begin
      result.word = acc_or;
    end

    if (done) begin
      acc_next  = '0;
      slot_next = 2'd0;
    end else begin
      acc_next  = acc_or;
      slot_next = slot + 2'd1;
    end
    if (msg_end) begin
      pos_next = '0;
    end else begin
      pos_next = pos_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc  <= '0;
      slot <= 2'd0;
      pos  <= '0;
    end else if (commit) begin
      acc  <= acc_next;
      slot <= slot_next;
      pos  <= pos_next;
    end
  end

endmodule

// ===== rtl/status_text_chunk_packer.sv =====
// Status text chunk packer: input register, character packer, copy emitter.
// Depends on stcp_pkg, stcp_pack and status_text_chunk_packer_assert.svh.

// Takes one message character per request and packs four characters into a
// 32-bit word, first character in bits 31..24. A word closes after four
// characters, on a NUL (which also ends the message and adds no byte), or when
// the message reaches TEXT_LEN characters. The last word of a message carries
// the severity in bits 23, 15 and 7. Each closed word is sent once, twice or
// three times as the request's link_rate falls below low_rate_limit, below
// mid_rate_limit, or neither; last_copy marks the final copy. A request is held
// in the input register, is packed in a single pass and lands in the result
// register, which offers its copies.
// The input takes one request per cycle unless stalled; each closed
// word then holds the result register until its copies have gone, and the input
// stalls only while a newly closed word waits behind copies still draining.
// Configure the rate limits only while the block is idle.
module status_text_chunk_packer #(
  parameter int unsigned TEXT_LEN = 50
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [stcp_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [stcp_pkg::RateW-1:0]    cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [stcp_pkg::CharW-1:0]    character,
  input  logic [stcp_pkg::SevW-1:0]     severity,
  input  logic [stcp_pkg::RateW-1:0]    link_rate,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [stcp_pkg::WordW-1:0]    chunk_word,
  output logic                          message_end,
  output logic                          last_copy
);
  import stcp_pkg::*;

  // Rate limit registers
  logic [RateW-1:0] low_rate_limit, mid_rate_limit;

  // Input register
  logic             in_full;
  logic [CharW-1:0] in_char;
  logic [SevW-1:0]  in_sev;
  logic [RateW-1:0] in_rate;

  // Result register: word plus copies still to send
  logic [WordW-1:0] out_word;
  logic             out_end;
  logic [CopyW-1:0] copies_left, copies_left_next;

  pack_result_t     pack_res;
  logic             out_free, advance, in_take;
  logic [CopyW-1:0] copies;

  always_ff @(posedge clk) begin
    if (rst) begin
      low_rate_limit <= LOW_RATE_RESET;
      mid_rate_limit <= MID_RATE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LOW_RATE: low_rate_limit <= cfg_data;
        REG_MID_RATE: mid_rate_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  stcp_pack #(
    .TEXT_LEN(TEXT_LEN)
  ) u_pack (
    .clk      (clk),
    .rst      (rst),
    .commit   (advance),
    .character(in_char),
    .severity (in_sev),
    .result   (pack_res)
  );

  // Low limit wins when the limits are out of order
  always_comb begin
    if (in_rate < low_rate_limit) begin
      copies = COPIES_ONE;
    end else if (in_rate < mid_rate_limit) begin
      copies = COPIES_TWO;
    end else begin
      copies = COPIES_THREE;
    end
  end

  // Result register frees up when empty or when its final copy leaves now
  assign out_free = (copies_left == '0) || (copies_left == 2'd1 && !out_stall);
  // Advance the held request unless it closes a word with nowhere to go
  assign advance  = in_full && (!pack_res.done || out_free);
  assign in_stall = in_full && !advance;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    copies_left_next = copies_left;
    if (copies_left != '0 && !out_stall) begin
      copies_left_next = copies_left - 2'd1;
    end
    if (advance && pack_res.done) begin
      copies_left_next = copies;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full     <= 1'b0;
      copies_left <= '0;
    end else begin
      copies_left <= copies_left_next;
      if (in_take) begin
        in_full <= 1'b1;
      end else if (advance) begin
        in_full <= 1'b0;
      end
    end
  end

  // Payload registers: hold unless a new request or a new word arrives
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_char <= character;
      in_sev  <= severity;
      in_rate <= link_rate;
    end
    if (advance && pack_res.done) begin
      out_word <= pack_res.word;
      out_end  <= pack_res.msg_end;
    end
  end

  assign out_valid   = (copies_left != '0);
  assign chunk_word  = out_word;
  assign message_end = out_end;
  assign last_copy   = (copies_left == 2'd1);

  `include "status_text_chunk_packer_assert.svh"

  // A copy that is not the last is followed by another copy of the same word
  `STCP_ASSERT_NEXT(a_repeat_follows,
                    out_valid && !out_stall && !last_copy,
                    out_valid && $stable(chunk_word) && $stable(message_end))
  // A stalled input request stays held in the input register
  `STCP_ASSERT_NEXT(a_stall_holds, in_stall, in_full)
  // The input stalls only when the result register is still busy
  `STCP_ASSERT_NOW(a_stall_cause, in_stall, out_valid)

endmodule

// ===== dv/status_text_chunk_packer_tb.sv =====
// Self-checking testbench for status_text_chunk_packer: packs random and directed
// message character streams and compares every emitted word copy with its own prediction.
// Depends on stcp_pkg and the status_text_chunk_packer RTL.
module status_text_chunk_packer_tb;
  import stcp_pkg::*;

  localparam int unsigned TEXT_LEN     = 50;
  // Nothing accepted on either side for this long means the block is hung. The slowest
  // correct stretch is the receiver hold-off below plus the drain.
  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned HOLD_AFTER   = 120;  // requests accepted before the hold-off
  localparam int unsigned HOLD_BACKLOG = 20;   // requests still queued when it starts
  localparam int unsigned DRAIN_CYCLES = 8;    // covers the input and result registers plus margin
  localparam int unsigned PHASE_REQS   = 30;
  localparam int unsigned NUM_PHASES   = 5;
  localparam int unsigned GAP_PERIOD   = 1500; // gaps only in the part of each
  localparam int unsigned GAP_FREE     = 300;  // window past GAP_FREE, so every window has a clean stretch

  typedef struct packed {
    logic [CharW-1:0] ch;
    logic [SevW-1:0]  sev;
    logic [RateW-1:0] rate;
  } char_req_t;

  typedef struct packed {
    logic [WordW-1:0] word;
    logic             msg_end;
    logic             last;
  } chunk_copy_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = REG_LOW_RATE;
  logic [RateW-1:0]    cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [CharW-1:0]    character = '0;
  logic [SevW-1:0]     severity = '0;
  logic [RateW-1:0]    link_rate = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [WordW-1:0]    chunk_word;
  logic                message_end;
  logic                last_copy;

  char_req_t   pending_chars[$];
  chunk_copy_t expected_copies[$];
  chunk_copy_t oldest_copy;

  // Predictor state: rate limits as last written, and the partial word being built.
  logic [RateW-1:0] low_limit = LOW_RATE_RESET;
  logic [RateW-1:0] mid_limit = MID_RATE_RESET;
  logic [WordW-1:0] partial_word = '0;
  logic [1:0]       byte_slot = '0;
  logic [5:0]       text_pos = '0;

  int unsigned req_count = 0;
  int unsigned cycle_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;
  int unsigned failures = 0;
  logic        gaps_allowed;

  status_text_chunk_packer #(.TEXT_LEN(TEXT_LEN)) dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .character(character), .severity(severity), .link_rate(link_rate),
    .out_valid(out_valid), .out_stall(out_stall),
    .chunk_word(chunk_word), .message_end(message_end), .last_copy(last_copy)
  );

  always #5 clk = ~clk;

  assign gaps_allowed = (cycle_count % GAP_PERIOD) >= GAP_FREE;

  // Fold one accepted character into the partial word; queue every copy of a word it closes.
  task automatic pack_character(input logic [CharW-1:0] ch, input logic [SevW-1:0] sev,
                                input logic [RateW-1:0] rate);
    logic             word_done;
    logic             msg_end;
    logic [WordW-1:0] word;
    int               copies;
    word_done = 1'b0;
    msg_end = 1'b0;
    if (ch == '0) begin
      // NUL closes the message and adds no byte
      word_done = 1'b1;
      msg_end = 1'b1;
    end else begin
      partial_word[8 * (3 - int'(byte_slot)) +: 8] =
        partial_word[8 * (3 - int'(byte_slot)) +: 8] | ch;
      text_pos = text_pos + 6'd1;
      if (byte_slot == 2'd3) word_done = 1'b1;
      byte_slot = byte_slot + 2'd1;
      // length limit closes the message without a NUL
      if (text_pos == 6'(TEXT_LEN)) begin
        word_done = 1'b1;
        msg_end = 1'b1;
      end
    end
    if (!word_done) return;
    word = partial_word;
    if (msg_end) begin
      // severity lands on the top bit of the three lower bytes
      word[23] = word[23] | sev[2];
      word[15] = word[15] | sev[1];
      word[7]  = word[7]  | sev[0];
      text_pos = '0;
    end
    partial_word = '0;
    byte_slot = '0;
    // low limit wins when the limits are out of order
    if (rate < low_limit) copies = 1;
    else if (rate < mid_limit) copies = 2;
    else copies = 3;
    for (int k = 0; k < copies; k++)
      expected_copies.push_back('{word: word, msg_end: msg_end, last: (k == copies - 1)});
  endtask

  task automatic add_request(input logic [CharW-1:0] ch, input logic [SevW-1:0] sev,
                             input logic [RateW-1:0] rate);
    pending_chars.push_back('{ch: ch, sev: sev, rate: rate});
  endtask

  // Mostly uniform rates, with a good share right at the copy-count boundaries.
  function automatic logic [RateW-1:0] pick_rate();
    case ($urandom_range(0, 9))
      0: return low_limit - 8'd1;
      1: return low_limit;
      2: return mid_limit - 8'd1;
      3: return mid_limit;
      default: return RateW'($urandom_range(0, 255));
    endcase
  endfunction

  // Well-formed message: nonzero characters, then NUL. Long ones run into the length limit.
  task automatic queue_message();
    int unsigned      len;
    int unsigned      roll;
    logic [SevW-1:0]  sev;
    roll = $urandom_range(0, 99);
    sev = SevW'($urandom_range(0, 7));
    if (roll < 65) len = $urandom_range(0, 8);
    else if (roll < 85) len = $urandom_range(9, 48);
    else len = $urandom_range(49, 63);
    for (int unsigned i = 0; i < len; i++)
      add_request(CharW'($urandom_range(1, 255)), sev, pick_rate());
    add_request('0, sev, pick_rate());
  endtask

  // Noise: a short burst of any characters, stray NULs included.
  task automatic queue_noise();
    int unsigned n;
    n = $urandom_range(1, 6);
    repeat (n) begin
      add_request(($urandom_range(0, 3) == 0) ? CharW'(0) : CharW'($urandom_range(1, 255)),
                  SevW'($urandom_range(0, 7)), pick_rate());
    end
  endtask

  task automatic write_limits(input logic [RateW-1:0] low, input logic [RateW-1:0] mid);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_LOW_RATE;
    cfg_data <= low;
    @(posedge clk);
    cfg_index <= REG_MID_RATE;
    cfg_data <= mid;
    @(posedge clk);
    cfg_we <= 1'b0;
    low_limit = low;
    mid_limit = mid;
  endtask

  // Wait until every request is in and every predicted copy is out, then let any
  // request that closes no word clear the pipeline.
  task automatic wait_idle();
    while (pending_chars.size() != 0 || in_valid || expected_copies.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic note_failure(input string what);
    if (failures < 10) $display("mismatch: %s", what);
    failures++;
  endtask

  // Request driver: predict on acceptance, then offer the next queued request or go idle.
  // A stalled request holds its payload and valid.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        pack_character(character, severity, link_rate);
        req_count <= req_count + 1;
      end
      if (!in_valid || !in_stall) begin
        if (pending_chars.size() != 0 && !(gaps_allowed && $urandom_range(0, 99) < 10)) begin
          in_valid <= 1'b1;
          character <= pending_chars[0].ch;
          severity <= pending_chars[0].sev;
          link_rate <= pending_chars[0].rate;
          void'(pending_chars.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off partway through so the block backs
  // up and stalls its input while the driver keeps offering.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (!hold_done && req_count >= HOLD_AFTER &&
                 pending_chars.size() >= HOLD_BACKLOG) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= gaps_allowed && ($urandom_range(0, 99) < 10);
    end
  end

  // Result checker: compare every accepted copy with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_copies.size() == 0) begin
        note_failure($sformatf("unexpected word %h end %b last %b",
                               chunk_word, message_end, last_copy));
      end else begin
        oldest_copy = expected_copies.pop_front();
        if (chunk_word !== oldest_copy.word || message_end !== oldest_copy.msg_end ||
            last_copy !== oldest_copy.last)
          note_failure($sformatf("word %h end %b last %b, expected word %h end %b last %b",
                                 chunk_word, message_end, last_copy, oldest_copy.word,
                                 oldest_copy.msg_end, oldest_copy.last));
      end
    end
  end

  // Watchdog: count cycles in which nothing moves on any port.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("** status_text_chunk_packer: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [RateW-1:0] low;
    logic [RateW-1:0] mid;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed part, reset limits 20 and 30.
    // NUL at the start of a word: all-zero word plus full severity, one copy
    add_request(8'h00, 3'd7, 8'd0);
    // all-ones characters fill a word, three copies
    add_request(8'hFF, 3'd0, 8'd19);
    add_request(8'hFF, 3'd0, 8'd20);
    add_request(8'hFF, 3'd0, 8'd29);
    add_request(8'hFF, 3'd0, 8'd255);
    // that message ends on a fresh word
    add_request(8'h00, 3'd5, 8'd30);
    // a high-bit and a low-bit character, then NUL with full severity
    add_request(8'h80, 3'd0, 8'd100);
    add_request(8'h01, 3'd0, 8'd100);
    add_request(8'h00, 3'd7, 8'd20);
    // NUL after three and after one character
    add_request(8'h41, 3'd2, 8'd29);
    add_request(8'h42, 3'd2, 8'd29);
    add_request(8'h43, 3'd2, 8'd29);
    add_request(8'h00, 3'd2, 8'd29);
    add_request(8'h7F, 3'd1, 8'd19);
    add_request(8'h00, 3'd1, 8'd19);
    add_request(8'h55, 3'd3, 8'd0);
    add_request(8'hAA, 3'd3, 8'd0);
    add_request(8'h01, 3'd3, 8'd0);
    add_request(8'h80, 3'd3, 8'd0);
    add_request(8'h00, 3'd3, 8'd255);
    wait_idle();

    // Random phases: extremes, out-of-order limits, the widest spread, then random limits.
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin low = 8'd0;   mid = 8'd0;   end
        1: begin low = 8'd255; mid = 8'd255; end
        2: begin low = 8'd200; mid = 8'd50;  end
        3: begin low = 8'd0;   mid = 8'd255; end
        default: begin
          low = RateW'($urandom_range(0, 255));
          mid = RateW'($urandom_range(0, 255));
        end
      endcase
      write_limits(low, mid);
      while (pending_chars.size() < PHASE_REQS) begin
        if ($urandom_range(0, 9) == 0) queue_noise();
        else queue_message();
      end
      wait_idle();
    end

    if (failures == 0 && expected_copies.size() == 0) begin
      $display("** status_text_chunk_packer: PASSED **");
    end else begin
      $display("** status_text_chunk_packer: FAILED **");
    end
    $finish;
  end

endmodule
